[src/ptst_pkg.sv]
// Shared constants and types for the pan/tilt slew position tracker.
`default_nettype none
package ptst_pkg;
	localparam int PRESET_SLOTS = 16;
	localparam int SLOT_W = (PRESET_SLOTS > 1) ? $clog2(PRESET_SLOTS) : 1;
	localparam int POS_W = 8;
	localparam int RATE_W = 8;
	localparam int ELAPSED_W = 18;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;
	localparam int PROD_W = ELAPSED_W + RATE_W;
	localparam int SUM_W = PROD_W + 1;
	localparam int DIV_Y_W = SUM_W - 3;
	localparam int RCP_W = 25;
	localparam logic [RCP_W-1:0] RCP_MULT = 25'd17179870;
	localparam int RCP_SHIFT = 31;
	localparam int RCP_PROD_W = DIV_Y_W + RCP_W;
	localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(500);
	localparam logic [RATE_W-1:0] RATE_RESET = 8'd15;

	localparam logic [2:0] REQ_TICK   = 3'd0;
	localparam logic [2:0] REQ_GOTO   = 3'd1;
	localparam logic [2:0] REQ_PRESET = 3'd2;
	localparam logic [2:0] REQ_HOME   = 3'd3;
	localparam logic [2:0] REQ_STORE  = 3'd4;
	localparam logic [2:0] REQ_READ   = 3'd5;
	localparam logic [2:0] REQ_QUERY  = 3'd6;

	localparam logic [1:0] REG_PAN_RATE  = 2'd0;
	localparam logic [1:0] REG_TILT_RATE = 2'd1;
	localparam logic [1:0] REG_HOME_PAN  = 2'd2;
	localparam logic [1:0] REG_HOME_TILT = 2'd3;

	typedef struct packed {
		logic [POS_W-1:0]     goal;
		logic [POS_W-1:0]     start;
		logic [ELAPSED_W-1:0] elapsed;
	} axis_t;
endpackage
`default_nettype wire

[src/ptst_if.sv]
// Request and response channel interfaces of the tracker.
`default_nettype none
interface ptst_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [7:0] pan;
	logic [7:0] tilt;
	logic [7:0] index;
	modport source (output valid, req_type, pan, tilt, index, input ready);
	modport sink (input valid, req_type, pan, tilt, index, output ready);
endinterface

interface ptst_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] pan_estimate;
	logic [7:0] tilt_estimate;
	logic [7:0] pan_target;
	logic [7:0] tilt_target;
	logic [7:0] read_pan;
	logic [7:0] read_tilt;
	logic       ok;
	modport source (output valid, pan_estimate, tilt_estimate, pan_target, tilt_target,
		read_pan, read_tilt, ok, input ready);
	modport sink (input valid, pan_estimate, tilt_estimate, pan_target, tilt_target,
		read_pan, read_tilt, ok, output ready);
endinterface
`default_nettype wire

[src/ptst_axis_est.sv]
// Two-stage slew interpolation of one axis: product, rounded divide by 1000, clamp.
`default_nettype none
module ptst_axis_est (
	input  wire logic                         clk,
	input  wire ptst_pkg::axis_t              axis,
	input  wire logic [ptst_pkg::RATE_W-1:0]  rate,
	output logic      [ptst_pkg::POS_W-1:0]   estimate
);
	import ptst_pkg::*;

	logic [PROD_W-1:0]     prod_s1;
	logic [ELAPSED_W-1:0]  move_s2;
	logic [SUM_W-1:0]      sum;
	logic [DIV_Y_W-1:0]    div_y;
	logic [RCP_PROD_W-1:0] rcp_prod;
	logic [POS_W-1:0]      distance;
	logic                  rising;

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(axis.elapsed) * PROD_W'(rate);
		move_s2 <= rcp_prod[RCP_SHIFT +: ELAPSED_W];
	end

	always_comb begin
		sum = {1'b0, prod_s1} + ROUND_BIAS;
		div_y = sum[SUM_W-1:3];
		rcp_prod = RCP_PROD_W'(div_y) * RCP_PROD_W'(RCP_MULT);
	end

	always_comb begin
		rising = axis.goal > axis.start;
		distance = rising ? axis.goal - axis.start : axis.start - axis.goal;
		if (axis.goal == axis.start || ELAPSED_W'(distance) <= move_s2) begin
			estimate = axis.goal;
		end else if (rising) begin
			estimate = axis.start + move_s2[POS_W-1:0];
		end else begin
			estimate = axis.start - move_s2[POS_W-1:0];
		end
	end
endmodule
`default_nettype wire

[src/pan_tilt_slew_position_tracker_unit.sv]
// Top level of the pan/tilt slew position tracker with its preset memory.
//
// A request beat on req_ch carries a tick, a goto, a preset recall, store or
// read, a home or a query; every request gives exactly one response beat on
// rsp_ch with both estimated positions, both servo targets, the preset read
// data and an ok flag. Rates and home positions must be written through the
// APB port only while idle; the block does not enforce this. Each request
// steps through ST_MUL, ST_RCP and ST_EST twice, passing through the
// estimator of each axis (multiply, then a reciprocal multiply for the divide
// by 1000) once before and once after the axis state is updated; the next
// request is accepted only once the block is back in ST_IDLE. Presets live in
// a synchronous memory whose read is issued when the request is accepted.
// Reset clears both axes, restores the rates to 15 and home to zero, and marks
// every preset slot empty so that it reads as zero; there is no clearing pass.
// A finished response waits in the output register while the receiver stalls;
// the block holds its last step until that register is free.
`default_nettype none
module pan_tilt_slew_position_tracker_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	ptst_req_if.sink        req_ch,
	ptst_rsp_if.source      rsp_ch,
	input  wire logic       psel,
	input  wire logic       penable,
	input  wire logic       pwrite,
	input  wire logic [3:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);
	import ptst_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL  = 4'b0010,
		ST_RCP  = 4'b0100,
		ST_EST  = 4'b1000
	} state_t;

	state_t state_q;
	logic   after_q;

	logic [RATE_W-1:0] pan_rate_q, tilt_rate_q;
	logic [POS_W-1:0]  home_pan_q, home_tilt_q;
	axis_t             pan_q, tilt_q;

	logic [2:0]        req_q;
	logic [POS_W-1:0]  pan_in_q, tilt_in_q;
	logic [SLOT_W-1:0] slot_q;
	logic              in_range_q;

	logic [2*POS_W-1:0] mem [PRESET_SLOTS];
	logic [2*POS_W-1:0] rdata_q;
	logic               rvalid_q;
	logic [PRESET_SLOTS-1:0] slot_valid_q;

	logic               rsp_valid_q;
	logic [POS_W-1:0]   rsp_pan_est_q, rsp_tilt_est_q, rsp_pan_tgt_q, rsp_tilt_tgt_q;
	logic [POS_W-1:0]   rsp_read_pan_q, rsp_read_tilt_q;
	logic               rsp_ok_q;

	logic [POS_W-1:0]   pan_est, tilt_est;
	logic [2*POS_W-1:0] entry;
	logic               req_fire, cfg_write, apply, finish, do_goto, mem_we, bad_index;
	logic [POS_W-1:0]   pan_tgt, tilt_tgt;
	logic [SLOT_W-1:0]  in_slot;
	logic               in_range;

	assign req_ch.ready = (state_q == ST_IDLE);
	assign req_fire = req_ch.valid && req_ch.ready;
	assign in_range = {1'b0, req_ch.index} < 9'(PRESET_SLOTS);
	assign in_slot = SLOT_W'(req_ch.index);
	assign pready = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	assign apply = (state_q == ST_EST) && !after_q;
	assign finish = (state_q == ST_EST) && after_q && (!rsp_valid_q || rsp_ch.ready);

	ptst_axis_est u_pan_est (
		.clk      (clk),
		.axis     (pan_q),
		.rate     (pan_rate_q),
		.estimate (pan_est)
	);

	ptst_axis_est u_tilt_est (
		.clk      (clk),
		.axis     (tilt_q),
		.rate     (tilt_rate_q),
		.estimate (tilt_est)
	);

	always_comb begin
		entry = rvalid_q ? rdata_q : '0;
		bad_index = !in_range_q &&
			(req_q == REQ_PRESET || req_q == REQ_STORE || req_q == REQ_READ);
		do_goto = 1'b0;
		pan_tgt = pan_in_q;
		tilt_tgt = tilt_in_q;
		case (req_q)
			REQ_GOTO: begin
				do_goto = 1'b1;
			end
			REQ_PRESET: begin
				do_goto = in_range_q;
				pan_tgt = entry[2*POS_W-1:POS_W];
				tilt_tgt = entry[POS_W-1:0];
			end
			REQ_HOME: begin
				do_goto = 1'b1;
				pan_tgt = home_pan_q;
				tilt_tgt = home_tilt_q;
			end
			default: begin
				do_goto = 1'b0;
			end
		endcase
		mem_we = apply && (req_q == REQ_STORE) && in_range_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[slot_q] <= {pan_in_q, tilt_in_q};
		end
		if (req_fire) begin
			rdata_q <= mem[in_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req_ch.req_type;
			pan_in_q <= req_ch.pan;
			tilt_in_q <= req_ch.tilt;
			slot_q <= in_slot;
			in_range_q <= in_range;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (mem_we) begin
				slot_valid_q[slot_q] <= 1'b1;
			end
			if (req_fire) begin
				rvalid_q <= slot_valid_q[in_slot];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_rate_q <= RATE_RESET;
			tilt_rate_q <= RATE_RESET;
			home_pan_q <= '0;
			home_tilt_q <= '0;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_PAN_RATE:  pan_rate_q <= pwdata[RATE_W-1:0];
				REG_TILT_RATE: tilt_rate_q <= pwdata[RATE_W-1:0];
				REG_HOME_PAN:  home_pan_q <= pwdata[POS_W-1:0];
				REG_HOME_TILT: home_tilt_q <= pwdata[POS_W-1:0];
				default:       pan_rate_q <= pan_rate_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_PAN_RATE:  prdata = 32'(pan_rate_q);
			REG_TILT_RATE: prdata = 32'(tilt_rate_q);
			REG_HOME_PAN:  prdata = 32'(home_pan_q);
			REG_HOME_TILT: prdata = 32'(home_tilt_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			after_q <= 1'b0;
			pan_q <= '0;
			tilt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_MUL;
						after_q <= 1'b0;
					end
				end
				ST_MUL: begin
					state_q <= ST_RCP;
				end
				ST_RCP: begin
					state_q <= ST_EST;
				end
				ST_EST: begin
					if (!after_q) begin
						state_q <= ST_MUL;
						after_q <= 1'b1;
						if (req_q == REQ_TICK) begin
							if (pan_q.elapsed != ELAPSED_MAX) begin
								pan_q.elapsed <= pan_q.elapsed + ELAPSED_W'(1);
							end
							if (tilt_q.elapsed != ELAPSED_MAX) begin
								tilt_q.elapsed <= tilt_q.elapsed + ELAPSED_W'(1);
							end
						end
						if (do_goto && pan_tgt != pan_q.goal) begin
							pan_q <= '{goal: pan_tgt, start: pan_est, elapsed: '0};
						end
						if (do_goto && tilt_tgt != tilt_q.goal) begin
							tilt_q <= '{goal: tilt_tgt, start: tilt_est, elapsed: '0};
						end
					end else if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (finish) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ch.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			rsp_pan_est_q <= pan_est;
			rsp_tilt_est_q <= tilt_est;
			rsp_pan_tgt_q <= pan_q.goal;
			rsp_tilt_tgt_q <= tilt_q.goal;
			rsp_ok_q <= !bad_index;
			if (req_q == REQ_READ && in_range_q) begin
				rsp_read_pan_q <= entry[2*POS_W-1:POS_W];
				rsp_read_tilt_q <= entry[POS_W-1:0];
			end else begin
				rsp_read_pan_q <= '0;
				rsp_read_tilt_q <= '0;
			end
		end
	end

	assign rsp_ch.valid = rsp_valid_q;
	assign rsp_ch.pan_estimate = rsp_pan_est_q;
	assign rsp_ch.tilt_estimate = rsp_tilt_est_q;
	assign rsp_ch.pan_target = rsp_pan_tgt_q;
	assign rsp_ch.tilt_target = rsp_tilt_tgt_q;
	assign rsp_ch.read_pan = rsp_read_pan_q;
	assign rsp_ch.read_tilt = rsp_read_tilt_q;
	assign rsp_ch.ok = rsp_ok_q;
endmodule
`default_nettype wire

[dv/tb_pan_tilt_slew_position_tracker_unit.sv]
// Self-checking random testbench for the pan/tilt slew position tracker top level.
`timescale 1ns / 100ps

import ptst_pkg::*;

localparam logic [2:0] REQ_SPARE = 3'd7;
localparam logic [17:0] MS_CEILING = 18'h3FFFF;

typedef struct packed {
	logic [2:0] kind;
	logic [7:0] pan;
	logic [7:0] tilt;
	logic [7:0] slot;
} request_t;

typedef struct packed {
	logic [7:0] pan_estimate;
	logic [7:0] tilt_estimate;
	logic [7:0] pan_target;
	logic [7:0] tilt_target;
	logic [7:0] read_pan;
	logic [7:0] read_tilt;
	logic       ok;
} status_t;

typedef struct packed {
	logic [7:0]  goal;
	logic [7:0]  origin;
	logic [17:0] ms;
} servo_axis_t;

class position_checker;
	logic [7:0] pan_rate;
	logic [7:0] tilt_rate;
	logic [7:0] home_pan;
	logic [7:0] home_tilt;
	servo_axis_t pan_axis;
	servo_axis_t tilt_axis;
	logic [7:0] preset_pan [PRESET_SLOTS];
	logic [7:0] preset_tilt [PRESET_SLOTS];
	status_t status_due [$];
	int unsigned errors;

	function new();
		pan_rate = RATE_RESET;
		tilt_rate = RATE_RESET;
		home_pan = '0;
		home_tilt = '0;
		pan_axis = '0;
		tilt_axis = '0;
		foreach (preset_pan[i]) begin
			preset_pan[i] = '0;
			preset_tilt[i] = '0;
		end
		errors = 0;
	endfunction

	function void set_register(logic [1:0] which, logic [7:0] value);
		case (which)
		REG_PAN_RATE: pan_rate = value;
		REG_TILT_RATE: tilt_rate = value;
		REG_HOME_PAN: home_pan = value;
		REG_HOME_TILT: home_tilt = value;
		default: ;
		endcase
	endfunction

	function logic [7:0] register_value(logic [1:0] which);
		case (which)
		REG_PAN_RATE: return pan_rate;
		REG_TILT_RATE: return tilt_rate;
		REG_HOME_PAN: return home_pan;
		REG_HOME_TILT: return home_tilt;
		default: return '0;
		endcase
	endfunction

	// The estimate runs from the origin toward the goal, rounded to the nearest unit.
	function logic [7:0] slewed_position(servo_axis_t a, logic [7:0] rate);
		int unsigned step;
		int unsigned span;
		if (a.goal == a.origin)
			return a.goal;
		step = (32'(a.ms) * 32'(rate) + 32'd500) / 32'd1000;
		span = (a.goal > a.origin) ? 32'(a.goal - a.origin) : 32'(a.origin - a.goal);
		if (span <= step)
			return a.goal;
		return (a.goal > a.origin) ? a.origin + step[7:0] : a.origin - step[7:0];
	endfunction

	function servo_axis_t steer_axis(servo_axis_t a, logic [7:0] target, logic [7:0] rate);
		servo_axis_t moved;
		moved = a;
		if (target != a.goal) begin
			moved.origin = slewed_position(a, rate);
			moved.goal = target;
			moved.ms = '0;
		end
		return moved;
	endfunction

	function void command_axes(logic [7:0] pan, logic [7:0] tilt);
		pan_axis = steer_axis(pan_axis, pan, pan_rate);
		tilt_axis = steer_axis(tilt_axis, tilt, tilt_rate);
	endfunction

	function void accept_request(request_t r);
		status_t want;
		logic in_range;
		in_range = (r.slot < PRESET_SLOTS);
		want = '0;
		want.ok = 1'b1;
		case (r.kind)
		REQ_TICK: begin
			if (pan_axis.ms != MS_CEILING)
				pan_axis.ms = pan_axis.ms + 1'b1;
			if (tilt_axis.ms != MS_CEILING)
				tilt_axis.ms = tilt_axis.ms + 1'b1;
		end
		REQ_GOTO: command_axes(r.pan, r.tilt);
		REQ_PRESET: begin
			if (in_range)
				command_axes(preset_pan[r.slot], preset_tilt[r.slot]);
			else
				want.ok = 1'b0;
		end
		REQ_HOME: command_axes(home_pan, home_tilt);
		REQ_STORE: begin
			if (in_range) begin
				preset_pan[r.slot] = r.pan;
				preset_tilt[r.slot] = r.tilt;
			end else begin
				want.ok = 1'b0;
			end
		end
		REQ_READ: begin
			if (in_range) begin
				want.read_pan = preset_pan[r.slot];
				want.read_tilt = preset_tilt[r.slot];
			end else begin
				want.ok = 1'b0;
			end
		end
		default: ;
		endcase
		want.pan_estimate = slewed_position(pan_axis, pan_rate);
		want.tilt_estimate = slewed_position(tilt_axis, tilt_rate);
		want.pan_target = pan_axis.goal;
		want.tilt_target = tilt_axis.goal;
		status_due.push_back(want);
	endfunction

	function int unsigned pending();
		return status_due.size();
	endfunction

	task report_mismatch(string what);
		errors++;
		$display("mismatch at %0t: %s", $time, what);
	endtask

	task check_status(status_t got);
		status_t want;
		if (status_due.size() == 0) begin
			report_mismatch("response beat with no request outstanding");
			return;
		end
		want = status_due.pop_front();
		if (got.pan_estimate !== want.pan_estimate)
			report_mismatch($sformatf("pan_estimate %0d, expected %0d",
				got.pan_estimate, want.pan_estimate));
		if (got.tilt_estimate !== want.tilt_estimate)
			report_mismatch($sformatf("tilt_estimate %0d, expected %0d",
				got.tilt_estimate, want.tilt_estimate));
		if (got.pan_target !== want.pan_target)
			report_mismatch($sformatf("pan_target %0d, expected %0d",
				got.pan_target, want.pan_target));
		if (got.tilt_target !== want.tilt_target)
			report_mismatch($sformatf("tilt_target %0d, expected %0d",
				got.tilt_target, want.tilt_target));
		if (got.read_pan !== want.read_pan)
			report_mismatch($sformatf("read_pan %0d, expected %0d",
				got.read_pan, want.read_pan));
		if (got.read_tilt !== want.read_tilt)
			report_mismatch($sformatf("read_tilt %0d, expected %0d",
				got.read_tilt, want.read_tilt));
		if (got.ok !== want.ok)
			report_mismatch($sformatf("ok %0b, expected %0b", got.ok, want.ok));
	endtask
endclass

module tb_pan_tilt_slew_position_tracker_unit;
	localparam int unsigned CYCLE_LIMIT = 8_000_000;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned PHASES = 8;
	localparam int unsigned ITEMS_PER_PHASE = 125;
	localparam int unsigned SETTLE_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int unsigned cycle_count = 0;
	bit sender_gaps = 1'b0;
	bit receiver_stalls = 1'b0;
	bit hold_off_pending = 1'b0;
	position_checker sb;

	ptst_req_if req_ch ();
	ptst_rsp_if rsp_ch ();

	pan_tilt_slew_position_tracker_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_ch(req_ch),
		.rsp_ch(rsp_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	always @(posedge clk) begin : response_monitor
		status_t seen;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			seen.pan_estimate = rsp_ch.pan_estimate;
			seen.tilt_estimate = rsp_ch.tilt_estimate;
			seen.pan_target = rsp_ch.pan_target;
			seen.tilt_target = rsp_ch.tilt_target;
			seen.read_pan = rsp_ch.read_pan;
			seen.read_tilt = rsp_ch.read_tilt;
			seen.ok = rsp_ch.ok;
			sb.check_status(seen);
		end
	end

	function automatic int unsigned gap_cycles();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(15, 60);
		return $urandom_range(1, 3);
	endfunction

	initial begin : response_sink
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				hold_off_pending = 1'b0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap_cycles()) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	function automatic request_t make_request(logic [2:0] kind, logic [7:0] pan,
			logic [7:0] tilt, logic [7:0] slot);
		request_t r;
		r.kind = kind;
		r.pan = pan;
		r.tilt = tilt;
		r.slot = slot;
		return r;
	endfunction

	function automatic request_t random_request();
		request_t r;
		int unsigned pick;
		r.pan = 8'($urandom);
		r.tilt = 8'($urandom);
		if ($urandom_range(0, 9) == 0)
			r.pan = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 9) == 0)
			r.tilt = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		if ($urandom_range(0, 5) == 0)
			r.slot = 8'($urandom);
		else
			r.slot = 8'($urandom_range(0, PRESET_SLOTS - 1));
		pick = $urandom_range(0, 99);
		if (pick < 45)
			r.kind = REQ_TICK;
		else if (pick < 60)
			r.kind = REQ_GOTO;
		else if (pick < 68)
			r.kind = REQ_PRESET;
		else if (pick < 73)
			r.kind = REQ_HOME;
		else if (pick < 84)
			r.kind = REQ_STORE;
		else if (pick < 94)
			r.kind = REQ_READ;
		else if (pick < 98)
			r.kind = REQ_QUERY;
		else
			r.kind = REQ_SPARE;
		if (r.kind == REQ_GOTO && $urandom_range(0, 3) == 0) begin
			pick = $urandom_range(0, 2);
			if (pick != 1)
				r.pan = sb.pan_axis.goal;
			if (pick != 0)
				r.tilt = sb.tilt_axis.goal;
		end
		return r;
	endfunction

	task automatic send_request(input request_t r);
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.kind;
		req_ch.pan <= r.pan;
		req_ch.tilt <= r.tilt;
		req_ch.index <= r.slot;
		do @(posedge clk); while (!req_ch.ready);
		sb.accept_request(r);
	endtask

	task automatic pause_requests(input int unsigned cycles);
		req_ch.valid <= 1'b0;
		req_ch.req_type <= 3'($urandom);
		req_ch.pan <= 8'($urandom);
		req_ch.tilt <= 8'($urandom);
		req_ch.index <= 8'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	task automatic drain_results();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] which, input logic [7:0] value);
		logic [7:0] seen;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {which, 2'b00};
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(which, value);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		seen = prdata[7:0];
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (seen !== sb.register_value(which))
			sb.report_mismatch($sformatf("register %0d reads %0d, expected %0d",
				which, seen, sb.register_value(which)));
	endtask

	task automatic apply_settings(input logic [7:0] pan_rate, input logic [7:0] tilt_rate,
			input logic [7:0] home_pan, input logic [7:0] home_tilt);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_register(REG_PAN_RATE, pan_rate);
		write_register(REG_TILT_RATE, tilt_rate);
		write_register(REG_HOME_PAN, home_pan);
		write_register(REG_HOME_TILT, home_tilt);
	endtask

	initial begin : stimulus
		request_t r;
		int unsigned burst;
		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_QUERY;
		req_ch.pan = '0;
		req_ch.tilt = '0;
		req_ch.index = '0;
		rsp_ch.ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_request(REQ_QUERY, 8'd0, 8'd0, 8'd0));
		send_request(make_request(REQ_SPARE, 8'hFF, 8'hFF, 8'hFF));
		send_request(make_request(REQ_READ, 8'd0, 8'd0, 8'd0));
		send_request(make_request(REQ_STORE, 8'hFF, 8'hFF, 8'd15));
		send_request(make_request(REQ_STORE, 8'd1, 8'd2, 8'd16));
		send_request(make_request(REQ_STORE, 8'd3, 8'd4, 8'hFF));
		send_request(make_request(REQ_READ, 8'd0, 8'd0, 8'd15));
		send_request(make_request(REQ_READ, 8'd0, 8'd0, 8'd16));
		send_request(make_request(REQ_READ, 8'd0, 8'd0, 8'hFF));
		send_request(make_request(REQ_STORE, 8'h5A, 8'hA5, 8'd0));
		send_request(make_request(REQ_GOTO, 8'hFF, 8'h00, 8'd0));
		send_request(make_request(REQ_TICK, 8'd0, 8'd0, 8'd0));
		send_request(make_request(REQ_TICK, 8'hFF, 8'hFF, 8'hFF));
		send_request(make_request(REQ_TICK, 8'd0, 8'd0, 8'd0));
		send_request(make_request(REQ_GOTO, 8'hFF, 8'h80, 8'd0));
		send_request(make_request(REQ_PRESET, 8'd0, 8'd0, 8'd15));
		send_request(make_request(REQ_PRESET, 8'd0, 8'd0, 8'd16));
		send_request(make_request(REQ_PRESET, 8'd0, 8'd0, 8'd0));
		send_request(make_request(REQ_HOME, 8'd0, 8'd0, 8'd0));
		send_request(make_request(REQ_HOME, 8'd0, 8'd0, 8'd0));
		send_request(make_request(REQ_TICK, 8'd0, 8'd0, 8'd0));
		send_request(make_request(REQ_QUERY, 8'd0, 8'd0, 8'd0));

		apply_settings(8'd1, 8'd1, 8'hFF, 8'hFF);
		send_request(make_request(REQ_HOME, 8'd0, 8'd0, 8'd0));
		send_request(make_request(REQ_QUERY, 8'd0, 8'd0, 8'd0));

		for (int p = 0; p < PHASES; p++) begin
			case (p)
			0: apply_settings(8'hFF, 8'hFF, 8'h00, 8'hFF);
			1: apply_settings(8'h00, 8'h00, 8'($urandom), 8'($urandom));
			2: apply_settings(8'hFF, 8'h01, 8'($urandom), 8'($urandom));
			default: apply_settings(8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)),
				8'($urandom), 8'($urandom));
			endcase
			sender_gaps = (p != 2);
			receiver_stalls = (p != 2);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (p == 3 && n == 40) begin
					hold_off_pending = 1'b1;
					sender_gaps = 1'b0;
				end
				if (p == 3 && n == 80)
					sender_gaps = 1'b1;
				if (p == 5 && n == 60)
					drain_results();
				r = random_request();
				if (r.kind == REQ_TICK && $urandom_range(0, 9) == 0) begin
					burst = $urandom_range(2, 8);
					repeat (burst) send_request(r);
				end else begin
					send_request(r);
				end
				if (sender_gaps && $urandom_range(0, 2) == 0)
					pause_requests(gap_cycles());
			end
		end

		drain_results();
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

[filelist.f]
src/ptst_pkg.sv
src/ptst_if.sv
src/ptst_axis_est.sv
src/pan_tilt_slew_position_tracker_unit.sv
dv/tb_pan_tilt_slew_position_tracker_unit.sv
